// File: hw/rtl/stq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg: shared codes for the sorted timer queue
// Operation and result kind codes used by the datapath and the top level.
// ----------------------------------------------------------------------------
package stq_pkg;
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  localparam int KEY_W = 32;
endpackage

// File: hw/rtl/stq_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_slot_mem: timer slot storage
// Expiry, period, periodic flag and order key per slot, one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
module stq_slot_mem #(
  parameter int NUM_TIMERS = 16,
  parameter int TICK_WIDTH = 32,
  parameter int ID_W       = 4,
  parameter int WORD_W     = 2 * TICK_WIDTH + 1 + 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ID_W-1:0]   waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [ID_W-1:0]   raddr,
  output logic [WORD_W-1:0] rdata_r
);
  logic [WORD_W-1:0] mem [NUM_TIMERS];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule

// File: hw/rtl/sorted_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue: sorted one-shot and periodic timer queue
// Slot state lives in a single-port-read memory; a sequencer scans it.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_* and raise start while busy is low to issue a transaction:
//   start timer, stop timer or tick. Results appear on out_* for one cycle
//   with out_valid high; out_last marks the final result of a transaction.
//   A start passes through the enqueue and response states, a stop or
//   undefined op through the response state only; each answers with its one
//   result in the first cycle after busy falls.
//   A tick scans all NUM_TIMERS slots through the memory read port, one slot
//   a cycle, to find the earliest due timer, fires it, and scans again.
//   Each firing is shown one firing late so the final one carries out_last;
//   the final result appears in the first cycle after busy falls.
//   When the insertion counter saturates, a renumbering pass runs inside
//   the transaction.
//   Reset clears the queued marks and the insertion counter; the memory is
//   not cleared and needs no pass. The receiver cannot stall: every result
//   is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
  parameter int NUM_TIMERS = 16,
  parameter int TICK_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_op,
  input  logic [3:0]            in_timer_id,
  input  logic [TICK_WIDTH-1:0] in_delay,
  input  logic                  in_periodic,
  input  logic [TICK_WIDTH-1:0] in_now_tick,
  output logic                  out_valid,
  output logic [1:0]            out_kind,
  output logic [3:0]            out_fired_id,
  output logic                  out_last
);
  import stq_pkg::*;

  localparam int ID_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W  = $clog2(NUM_TIMERS + 1);
  localparam int WORD_W = 2 * TICK_WIDTH + 1 + KEY_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FIRE  = 3'd2;
  localparam logic [2:0] S_RSCAN = 3'd3;
  localparam logic [2:0] S_RPUT  = 3'd4;
  localparam logic [2:0] S_ENQ   = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0]            state_r, state_nxt;
  logic [NUM_TIMERS-1:0] queued_r, queued_nxt;
  logic [NUM_TIMERS-1:0] fired_r, fired_nxt;
  logic [NUM_TIMERS-1:0] done_r, done_nxt;
  logic [KEY_W-1:0]      ctr_r, ctr_nxt;
  logic [3:0]            id_r;
  logic [TICK_WIDTH-1:0] now_r;
  logic                  any_r, any_nxt;
  logic [CNT_W-1:0]      rcnt_r, rcnt_nxt;
  logic [ID_W:0]         scan_r, scan_nxt;
  logic                  rvld_r;
  logic [ID_W-1:0]       rid_r;
  logic                  have_r, have_nxt;
  logic [ID_W-1:0]       pick_r, pick_nxt;
  logic [TICK_WIDTH-1:0] pexp_r, pexp_nxt;
  logic [KEY_W-1:0]      pkey_r, pkey_nxt;
  logic [TICK_WIDTH-1:0] pper_r, pper_nxt;
  logic                  prep_r, prep_nxt;
  logic                  enq_tick_r, enq_tick_nxt;
  logic [3:0]            pend_id_r, pend_id_nxt;

  // hold pending entry through renumbering
  logic [TICK_WIDTH-1:0] sexp_r, sper_r;
  logic                  srep_r;
  logic [ID_W-1:0]       sid_r;

  logic                  we;
  logic [ID_W-1:0]       waddr, raddr;
  logic [WORD_W-1:0]     wdata, rdata_r;
  logic [TICK_WIDTH-1:0] r_exp, r_per;
  logic                  r_rep;
  logic [KEY_W-1:0]      r_key;
  logic                  id_ok;
  logic [ID_W-1:0]       in_slot;
  logic                  ov, ol;
  logic [1:0]            ok;
  logic [3:0]            oi;
  logic [TICK_WIDTH-1:0] p1;

  stq_slot_mem #(
    .NUM_TIMERS(NUM_TIMERS), .TICK_WIDTH(TICK_WIDTH), .ID_W(ID_W), .WORD_W(WORD_W)
  ) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata_r(rdata_r)
  );

  assign {r_exp, r_per, r_rep, r_key} = rdata_r;
  assign raddr   = scan_r[ID_W-1:0];
  assign id_ok   = (32'(in_timer_id) < NUM_TIMERS);
  assign in_slot = ID_W'(in_timer_id);
  assign busy    = (state_r != S_IDLE);
  assign p1      = (pper_r == '0) ? TICK_WIDTH'(1) : pper_r;

  // sequencer
  always_comb begin
    logic cand;
    logic better;
    state_nxt = state_r; queued_nxt = queued_r; fired_nxt = fired_r;
    done_nxt = done_r; ctr_nxt = ctr_r; any_nxt = any_r; rcnt_nxt = rcnt_r;
    scan_nxt = scan_r; have_nxt = have_r; pick_nxt = pick_r; pexp_nxt = pexp_r;
    pkey_nxt = pkey_r; pper_nxt = pper_r; prep_nxt = prep_r; enq_tick_nxt = enq_tick_r;
    pend_id_nxt = pend_id_r;
    we = 1'b0; waddr = pick_r; wdata = {pexp_r, pper_r, prep_r, pkey_r};
    ov = 1'b0; ok = KIND_DONE; oi = id_r; ol = 1'b1;
    cand = 1'b0; better = 1'b0;
    case (state_r)
      S_IDLE: begin
        scan_nxt = '0; have_nxt = 1'b0;
        if (start) begin
          fired_nxt = '0; any_nxt = 1'b0;
          if (in_op == OP_START && id_ok) begin
            queued_nxt[in_slot] = 1'b0;
            pick_nxt = in_slot;
            pexp_nxt = in_now_tick + in_delay;
            pper_nxt = in_periodic ? in_delay : '0;
            prep_nxt = in_periodic;
            enq_tick_nxt = 1'b0;
            state_nxt = S_ENQ;
          end else if (in_op == OP_TICK) begin
            state_nxt = S_SCAN;
          end else begin
            if (in_op == OP_STOP && id_ok) queued_nxt[in_slot] = 1'b0;
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        ov = 1'b1;
        state_nxt = S_IDLE;
      end
      S_ENQ: begin
        // renumber first when the counter is full
        if (ctr_r == '1) begin
          queued_nxt[pick_r] = 1'b0;
          done_nxt = '0; rcnt_nxt = '0; scan_nxt = '0; have_nxt = 1'b0;
          state_nxt = S_RSCAN;
        end else begin
          we = 1'b1;
          wdata = {pexp_r, pper_r, prep_r, ctr_r};
          ctr_nxt = ctr_r + 1'b1;
          queued_nxt[pick_r] = 1'b1;
          if (enq_tick_r) begin
            scan_nxt = '0; have_nxt = 1'b0; state_nxt = S_SCAN;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SCAN: begin
        // compare the slot read last cycle against the best so far
        if (rvld_r) begin
          cand = queued_r[rid_r] && !fired_r[rid_r] && (r_exp <= now_r);
          better = !have_r || (r_exp < pexp_r) || (r_exp == pexp_r && r_key < pkey_r);
          if (cand && better) begin
            have_nxt = 1'b1; pick_nxt = rid_r; pexp_nxt = r_exp;
            pkey_nxt = r_key; pper_nxt = r_per; prep_nxt = r_rep;
          end
        end
        if (scan_r <= (ID_W+1)'(NUM_TIMERS - 1)) scan_nxt = scan_r + 1'b1;
        else if (!rvld_r) state_nxt = have_r ? S_FIRE : S_IDLE;
      end
      S_FIRE: begin
        // show the previous firing and hold this one back
        fired_nxt[pick_r] = 1'b1; queued_nxt[pick_r] = 1'b0; any_nxt = 1'b1;
        ov = any_r; ok = KIND_FIRED; oi = pend_id_r; ol = 1'b0;
        pend_id_nxt = 4'(pick_r);
        if (prep_r) begin
          pexp_nxt = now_r + p1; enq_tick_nxt = 1'b1; state_nxt = S_ENQ;
        end else begin
          scan_nxt = '0; have_nxt = 1'b0; state_nxt = S_SCAN;
        end
      end
      S_RSCAN: begin
        // find the smallest key not yet renumbered
        if (rvld_r) begin
          cand = queued_r[rid_r] && !done_r[rid_r];
          if (cand && (!have_r || r_key < pkey_r)) begin
            have_nxt = 1'b1; pick_nxt = rid_r; pexp_nxt = r_exp;
            pkey_nxt = r_key; pper_nxt = r_per; prep_nxt = r_rep;
          end
        end
        if (scan_r <= (ID_W+1)'(NUM_TIMERS - 1)) scan_nxt = scan_r + 1'b1;
        else if (!rvld_r) state_nxt = S_RPUT;
      end
      S_RPUT: begin
        if (have_r) begin
          we = 1'b1;
          wdata = {pexp_r, pper_r, prep_r, KEY_W'(rcnt_r)};
          done_nxt[pick_r] = 1'b1;
          rcnt_nxt = rcnt_r + 1'b1;
          scan_nxt = '0; have_nxt = 1'b0; state_nxt = S_RSCAN;
        end else begin
          // restore the pending entry and finish the insert
          ctr_nxt = KEY_W'(rcnt_r);
          pick_nxt = sid_r; pexp_nxt = sexp_r; pper_nxt = sper_r; prep_nxt = srep_r;
          state_nxt = S_ENQ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // end of tick: show the held firing as last, or report nothing due
    if (state_r == S_SCAN && state_nxt == S_IDLE) begin
      ov = 1'b1; ol = 1'b1;
      ok = any_r ? KIND_FIRED : KIND_NONE;
      oi = any_r ? pend_id_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; queued_r <= '0; ctr_r <= '0; rvld_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt; queued_r <= queued_nxt; ctr_r <= ctr_nxt;
      rvld_r <= (state_r == S_SCAN || state_r == S_RSCAN) &&
                (scan_r <= (ID_W+1)'(NUM_TIMERS - 1));
      out_valid <= ov;
    end
  end

  always_ff @(posedge clk) begin
    rid_r <= scan_r[ID_W-1:0];
    fired_r <= fired_nxt; done_r <= done_nxt; any_r <= any_nxt; rcnt_r <= rcnt_nxt;
    scan_r <= scan_nxt; have_r <= have_nxt; pkey_r <= pkey_nxt;
    enq_tick_r <= enq_tick_nxt; pend_id_r <= pend_id_nxt;
    if (state_r == S_ENQ && ctr_r == '1) begin
      sexp_r <= pexp_r; sper_r <= pper_r; srep_r <= prep_r; sid_r <= pick_r;
    end
    pick_r <= pick_nxt; pexp_r <= pexp_nxt; pper_r <= pper_nxt; prep_r <= prep_nxt;
    if (state_r == S_IDLE && start) begin
      id_r <= in_timer_id; now_r <= in_now_tick;
    end
    out_kind <= ok; out_fired_id <= oi; out_last <= ol;
  end
endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted timer queue
// Drives start, stop, tick and undefined-op transactions: a directed table
// first, then random traffic that follows a running tick count. A local
// timer-queue model predicts each result, or a directed row gives its own.
// A scoreboard checks each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import stq_pkg::*;

  localparam int NSLOT    = 16;
  localparam int CYC_MAX  = 500000;
  localparam int DRAIN    = 400;
  localparam logic [1:0] OP_UNDEF = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] id;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  id;
    logic [31:0] delay;
    logic        per;
    logic [31:0] now;
    logic        typed;
    result_t     res;
  } row_t;

  logic clk, rst_n, start, busy;
  logic [1:0]  in_op;
  logic [3:0]  in_timer_id;
  logic [31:0] in_delay;
  logic        in_periodic;
  logic [31:0] in_now_tick;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [3:0]  out_fired_id;
  logic        out_last;

  sorted_timer_queue dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_timer_id(in_timer_id), .in_delay(in_delay),
    .in_periodic(in_periodic), .in_now_tick(in_now_tick),
    .out_valid(out_valid), .out_kind(out_kind), .out_fired_id(out_fired_id),
    .out_last(out_last)
  );

  // Timer model state
  logic [31:0] slot_expiry [NSLOT];
  logic [31:0] slot_period [NSLOT];
  logic        slot_repeat [NSLOT];
  logic        slot_queued [NSLOT];
  logic [31:0] slot_key    [NSLOT];
  logic [31:0] insert_cnt;

  result_t pending_q[$];
  int      fail_cnt;
  int      cyc;
  int      idle_pct;
  logic [31:0] tick_now;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Renumber queued keys in their present order
  function automatic void compact_keys();
    logic done [NSLOT];
    logic [31:0] fresh [NSLOT];
    logic [31:0] n;
    int pick;
    n = 0;
    for (int i = 0; i < NSLOT; i++) begin
      done[i] = 1'b0;
      fresh[i] = '0;
    end
    for (int i = 0; i < NSLOT; i++) begin
      pick = -1;
      for (int j = 0; j < NSLOT; j++)
        if (slot_queued[j] && !done[j] && (pick < 0 || slot_key[j] < slot_key[pick]))
          pick = j;
      if (pick >= 0) begin
        done[pick] = 1'b1;
        fresh[pick] = n;
        n++;
      end
    end
    for (int i = 0; i < NSLOT; i++)
      if (slot_queued[i]) slot_key[i] = fresh[i];
    insert_cnt = n;
  endfunction

  function automatic void arm_slot(int s, logic [31:0] when);
    if (insert_cnt == 32'hFFFF_FFFF) begin
      slot_queued[s] = 1'b0;
      compact_keys();
    end
    slot_expiry[s] = when;
    slot_key[s] = insert_cnt;
    insert_cnt++;
    slot_queued[s] = 1'b1;
  endfunction

  // Apply one transaction to the model and queue the results it causes
  function automatic void predict_timer_events(logic [1:0] op, logic [3:0] id,
                                               logic [31:0] delay, logic per,
                                               logic [31:0] now);
    logic fired [NSLOT];
    int count;
    int pick;
    logic [31:0] p;
    result_t r;
    case (op)
      OP_START: begin
        slot_queued[id] = 1'b0;
        slot_period[id] = per ? delay : '0;
        slot_repeat[id] = per;
        arm_slot(id, now + delay);
        pending_q.push_back('{KIND_DONE, id, 1'b1});
      end
      OP_STOP: begin
        slot_queued[id] = 1'b0;
        pending_q.push_back('{KIND_DONE, id, 1'b1});
      end
      OP_TICK: begin
        count = 0;
        for (int i = 0; i < NSLOT; i++) fired[i] = 1'b0;
        forever begin
          pick = -1;
          for (int i = 0; i < NSLOT; i++) begin
            if (!slot_queued[i] || fired[i] || slot_expiry[i] > now) continue;
            if (pick < 0 || slot_expiry[i] < slot_expiry[pick] ||
                (slot_expiry[i] == slot_expiry[pick] && slot_key[i] < slot_key[pick]))
              pick = i;
          end
          if (pick < 0) break;
          fired[pick] = 1'b1;
          slot_queued[pick] = 1'b0;
          pending_q.push_back('{KIND_FIRED, pick[3:0], 1'b0});
          count++;
          if (slot_repeat[pick]) begin
            p = (slot_period[pick] == 0) ? 32'd1 : slot_period[pick];
            arm_slot(pick, now + p);
          end
        end
        if (count == 0) pending_q.push_back('{KIND_NONE, 4'd0, 1'b1});
        else begin
          r = pending_q.pop_back();
          r.last = 1'b1;
          pending_q.push_back(r);
        end
      end
      default: pending_q.push_back('{KIND_DONE, id, 1'b1});
    endcase
  endfunction

  // Issue one transaction and wait for acceptance
  task automatic send_txn(row_t rw);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_op = rw.op;
    in_timer_id = rw.id;
    in_delay = rw.delay;
    in_periodic = rw.per;
    in_now_tick = rw.now;
    start = 1'b1;
    do @(posedge clk); while (busy);
    predict_timer_events(rw.op, rw.id, rw.delay, rw.per, rw.now);
    if (rw.typed) begin
      void'(pending_q.pop_back());
      pending_q.push_back(rw.res);
    end
  endtask

  // Build a random transaction, mostly sane timer traffic around tick_now
  function automatic row_t rand_txn();
    row_t rw;
    int sel;
    rw = '0;
    rw.id = 4'($urandom_range(15));
    rw.per = 1'($urandom_range(1));
    sel = $urandom_range(99);
    if (sel < 45) begin
      rw.op = OP_START;
      rw.delay = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(40);
    end else if (sel < 60) begin
      rw.op = OP_STOP;
      rw.delay = $urandom();
    end else if (sel < 97) begin
      rw.op = OP_TICK;
      rw.delay = $urandom();
      if ($urandom_range(19) == 0) tick_now = $urandom();
      else tick_now = tick_now + $urandom_range(12);
    end else begin
      rw.op = OP_UNDEF;
      rw.delay = $urandom();
    end
    rw.now = tick_now;
    return rw;
  endfunction

  // Check each strobed result against the oldest prediction
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result kind=%0d id=%0d last=%0d", out_kind, out_fired_id,
               out_last);
        fail_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (out_kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_kind);
          fail_cnt++;
        end
        if (out_fired_id !== e.id) begin
          $error("fired_id: expected %0d, got %0d", e.id, out_fired_id);
          fail_cnt++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_last);
          fail_cnt++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cyc++;
    if (cyc >= CYC_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  row_t dir_tbl [] = '{
    // empty queue after reset: nothing due
    '{OP_TICK,  4'd0,  32'd0,          1'b0, 32'd0,  1'b1, '{KIND_NONE, 4'd0, 1'b1}},
    '{OP_START, 4'd0,  32'd0,          1'b0, 32'd0,  1'b1, '{KIND_DONE, 4'd0, 1'b1}},
    // expiry wraps to zero, period is max
    '{OP_START, 4'd15, 32'hFFFF_FFFF,  1'b1, 32'd1,  1'b1, '{KIND_DONE, 4'd15, 1'b1}},
    '{OP_START, 4'd3,  32'd5,          1'b1, 32'd0,  1'b0, '0},
    '{OP_START, 4'd4,  32'd5,          1'b0, 32'd0,  1'b0, '0},
    // zero period re-arms one tick later
    '{OP_START, 4'd5,  32'd0,          1'b1, 32'd10, 1'b0, '0},
    '{OP_START, 4'd9,  32'd100,        1'b0, 32'd10, 1'b0, '0},
    '{OP_START, 4'd9,  32'd1,          1'b0, 32'd10, 1'b0, '0},
    '{OP_TICK,  4'd0,  32'd0,          1'b0, 32'd10, 1'b0, '0},
    '{OP_TICK,  4'd0,  32'd0,          1'b0, 32'd11, 1'b0, '0},
    '{OP_STOP,  4'd3,  32'd0,          1'b0, 32'd11, 1'b1, '{KIND_DONE, 4'd3, 1'b1}},
    '{OP_STOP,  4'd3,  32'd0,          1'b0, 32'd11, 1'b1, '{KIND_DONE, 4'd3, 1'b1}},
    '{OP_UNDEF, 4'd7,  32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF, 1'b1, '{KIND_DONE, 4'd7, 1'b1}},
    '{OP_START, 4'd10, 32'd2,          1'b1, 32'hFFFF_FFFD, 1'b0, '0},
    '{OP_START, 4'd11, 32'd3,          1'b0, 32'hFFFF_FFF0, 1'b0, '0},
    '{OP_TICK,  4'd0,  32'd0,          1'b0, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_STOP,  4'd15, 32'd0,          1'b0, 32'd12, 1'b0, '0},
    '{OP_STOP,  4'd5,  32'd0,          1'b0, 32'd12, 1'b0, '0},
    '{OP_STOP,  4'd10, 32'd0,          1'b0, 32'd12, 1'b0, '0},
    '{OP_TICK,  4'd0,  32'd0,          1'b0, 32'hFFFF_FFFF, 1'b0, '0}
  };

  initial begin
    int waited;
    fail_cnt = 0;
    cyc = 0;
    idle_pct = 17;
    tick_now = 32'd20;
    insert_cnt = '0;
    for (int i = 0; i < NSLOT; i++) begin
      slot_queued[i] = 1'b0;
      slot_expiry[i] = '0;
      slot_period[i] = '0;
      slot_repeat[i] = 1'b0;
      slot_key[i] = '0;
    end
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_START;
    in_timer_id = '0;
    in_delay = '0;
    in_periodic = 1'b0;
    in_now_tick = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table
    foreach (dir_tbl[i]) send_txn(dir_tbl[i]);

    // Random traffic in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 17 : (ph == 1) ? 62 : 0;
      for (int n = 0; n < 27; n++) send_txn(rand_txn());
    end
    @(negedge clk);
    start = 1'b0;

    // Drain outstanding results, then let the block settle
    waited = 0;
    while (pending_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN) @(posedge clk);
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// File: sorted_timer_queue.f
hw/rtl/stq_pkg.sv
hw/rtl/stq_slot_mem.sv
hw/rtl/sorted_timer_queue.sv
sim/tb.sv
